FILE: hdl/tts_pkg.sv
// Shared types and constants for the task time statistics table.
package tts_pkg;

    localparam int TASKS = 64;
    localparam int IDX_W = $clog2(TASKS);

    localparam logic [31:0] ALL_ONES_32 = '1;
    localparam logic [47:0] ALL_ONES_48 = '1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [5:0]  task_id;
        logic [31:0] duration;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [31:0] run_count;
        logic [47:0] time_sum;
        logic [31:0] time_max;
        logic [31:0] time_min;
    } result_t;

    typedef struct packed {
        logic [31:0] count;
        logic [47:0] sum;
        logic [31:0] tmax;
        logic [31:0] tmin;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic write;
        logic respond;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic in_range;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

FILE: hdl/tts_datapath.sv
// Statistics table memory, valid bits and update arithmetic.
module tts_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  tts_pkg::item_t    item,
    input  tts_pkg::cmd_t     cmd,
    output tts_pkg::status_t  status,
    output tts_pkg::result_t  result
);

    tts_pkg::entry_t            mem [tts_pkg::TASKS];
    tts_pkg::entry_t            rd_reg;
    tts_pkg::item_t             item_reg;
    tts_pkg::result_t           result_reg;
    logic [tts_pkg::TASKS-1:0]  valid_reg;

    logic [tts_pkg::IDX_W-1:0]  idx;
    logic [tts_pkg::IDX_W-1:0]  rd_idx;
    logic                       in_range;
    logic                       hit;
    tts_pkg::entry_t            old_entry;
    tts_pkg::entry_t            new_entry;
    logic [48:0]                sum_wide;

    assign idx      = item_reg.task_id[tts_pkg::IDX_W-1:0];
    assign rd_idx   = item.task_id[tts_pkg::IDX_W-1:0];
    assign in_range = 32'(item_reg.task_id) < 32'(tts_pkg::TASKS);
    assign hit      = valid_reg[idx];

    assign status.is_query = (item_reg.kind == tts_pkg::KIND_QUERY);
    assign status.in_range = in_range;

    always_comb
    begin
        if (hit)
        begin
            old_entry = rd_reg;
        end
        else
        begin
            old_entry = '{count: 32'd0, sum: 48'd0, tmax: 32'd0,
                          tmin: tts_pkg::ALL_ONES_32};
        end
        new_entry = old_entry;
        if (old_entry.count != tts_pkg::ALL_ONES_32)
        begin
            new_entry.count = old_entry.count + 32'd1;
        end
        sum_wide = {1'b0, old_entry.sum} + 49'(item_reg.duration);
        // clamp the sum at the top of its range
        new_entry.sum = sum_wide[48] ? tts_pkg::ALL_ONES_48 : sum_wide[47:0];
        if (item_reg.duration > old_entry.tmax)
        begin
            new_entry.tmax = item_reg.duration;
        end
        if (item_reg.duration < old_entry.tmin)
        begin
            new_entry.tmin = item_reg.duration;
        end
    end

    // item latch and registered table read at the input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
            rd_reg   <= mem[rd_idx];
        end
        if (cmd.write)
        begin
            mem[idx] <= new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.write)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            if (in_range && hit)
            begin
                result_reg <= '{found: 1'b1, run_count: rd_reg.count,
                                time_sum: rd_reg.sum, time_max: rd_reg.tmax,
                                time_min: rd_reg.tmin};
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: hdl/tts_ctrl.sv
// Controller: sequences capture, update and result strobe for one item.
module tts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  tts_pkg::status_t  status,
    output tts_pkg::cmd_t     cmd,
    output logic              busy,
    output logic              done
);

    tts_pkg::state_t state_reg;
    tts_pkg::state_t state_next;
    logic            done_reg;

    assign busy = (state_reg == tts_pkg::ST_EXEC);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            tts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tts_pkg::ST_EXEC;
                end
            end
            tts_pkg::ST_EXEC:
            begin
                cmd.write   = !status.is_query && status.in_range;
                cmd.respond = status.is_query;
                state_next  = tts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tts_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.respond;
        end
    end

    assign done = done_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter update");

    a_single_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("update lasted more than one cycle");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a preceding update");

    a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write && cmd.respond))
        else $error("table write during a query");

endmodule

FILE: hdl/task_time_statistics_table_unit.sv
// Top level of the per-task execution time statistics table.
// A query's result strobe (done) is registered from the update state that follows its transfer.
// A new item is not accepted while busy: the registered table read precedes the
// read-modify-write in the update state; busy is high for that update cycle.
// The result strobe (done) is high for one cycle only; the receiver cannot stall.
// Reset clears the controller and all per-task valid bits; table data needs no clearing.
module task_time_statistics_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tts_pkg::item_t    item,
    output logic              done,
    output tts_pkg::result_t  result
);

    tts_pkg::cmd_t    cmd;
    tts_pkg::status_t status;

    tts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tts_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule
